>>> sv/pbts_pkg.sv
// ----------------------------------------------------------------------------
// pbts_pkg
// Shared field widths and request codes of the priority bitmap scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package pbts_pkg;

   localparam int FUNC_W      = 3;
   localparam int PRIO_FLD_W  = 5;
   localparam int TICKS_FLD_W = 32;
   localparam int LOCK_W      = 8;
   localparam int MASK_W      = 32;

   localparam logic [FUNC_W-1:0] FUNC_CREATE = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_DELAY  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_LOCK   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_UNLOCK = 3'd4;

   localparam logic [LOCK_W-1:0] LOCK_MAX = 8'd255;

endpackage

`default_nettype wire

>>> sv/pbts_req_if.sv
// ----------------------------------------------------------------------------
// pbts_req_if
// Request channel: scheduler call with its priority and tick count.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbts_req_if import pbts_pkg::*; ();

   logic                   valid;
   logic                   ready;
   logic [FUNC_W-1:0]      func;
   logic [PRIO_FLD_W-1:0]  prio;
   logic [TICKS_FLD_W-1:0] ticks;

   modport source (output valid, func, prio, ticks, input ready);
   modport sink   (input valid, func, prio, ticks, output ready);

endinterface

`default_nettype wire

>>> sv/pbts_rsp_if.sv
// ----------------------------------------------------------------------------
// pbts_rsp_if
// Result channel: running task, switch flag and scheduler status.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbts_rsp_if import pbts_pkg::*; ();

   logic                  valid;
   logic                  ready;
   logic [PRIO_FLD_W-1:0] next_prio;
   logic                  switch_now;
   logic                  none_ready;
   logic [LOCK_W-1:0]     lock_depth;
   logic [MASK_W-1:0]     ready_mask;

   modport source (output valid, next_prio, switch_now, none_ready, lock_depth, ready_mask,
                   input ready);
   modport sink   (input valid, next_prio, switch_now, none_ready, lock_depth, ready_mask,
                   output ready);

endinterface

`default_nettype wire

>>> sv/pbts_ram.sv
// ----------------------------------------------------------------------------
// pbts_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pbts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> sv/priority_bitmap_task_scheduler_top.sv
// ----------------------------------------------------------------------------
// priority_bitmap_task_scheduler_top
// One-task-per-priority scheduler: ready bitmap, tick delays kept in RAM,
// nested scheduler lock and lowest-number-first selection.
//
//   channel   dir   handshake          payload
//   req_bus   in    valid / ready      func, prio, ticks
//   rsp_bus   out   valid / ready      next_prio, switch_now, none_ready,
//                                      lock_depth, ready_mask
//
// Create, delay, lock, unlock: accept leads to the schedule step, which
// registers the result once the output is free. Tick: one delay counter
// per cycle through the single read port of the delay RAM, then schedule.
// One request in flight; the next is accepted once the result is registered,
// even while it waits on rsp_bus.ready. A stalled result holds the block.
// Synchronous reset clears bitmaps, lock count and running task; the delay
// RAM is not cleared, entries are used only after a delay has written them.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_bitmap_task_scheduler_top import pbts_pkg::*; #(
   parameter int PRIO_COUNT = 32,
   parameter int TICK_WIDTH = 32
) (
   input  wire logic   clock,
   input  wire logic   reset,
   pbts_req_if.sink    req_bus,
   pbts_rsp_if.source  rsp_bus
);

   localparam int PRIO_W = $clog2(PRIO_COUNT);
   localparam int CNT_W  = $clog2(PRIO_COUNT + 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_WALK  = 2'd1;
   localparam logic [1:0] S_SCHED = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [PRIO_COUNT-1:0] ready_ff, ready_in;
   logic [PRIO_COUNT-1:0] delayed_ff, delayed_in;
   logic [LOCK_W-1:0]     lock_ff, lock_in;
   logic [PRIO_W-1:0]     running_ff, running_in;
   logic                  sched_ff, sched_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  wb_vld_ff, wb_vld_in;
   logic [PRIO_W-1:0]     wb_idx_ff, wb_idx_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PRIO_FLD_W-1:0] rsp_prio_ff, rsp_prio_in;
   logic                  rsp_switch_ff, rsp_switch_in;
   logic                  rsp_none_ff, rsp_none_in;
   logic [LOCK_W-1:0]     rsp_lock_ff, rsp_lock_in;
   logic [MASK_W-1:0]     rsp_mask_ff, rsp_mask_in;

   logic                  ram_wr_en;
   logic [PRIO_W-1:0]     ram_wr_addr;
   logic [TICK_WIDTH-1:0] ram_wr_data;
   logic [PRIO_W-1:0]     ram_rd_addr;
   logic [TICK_WIDTH-1:0] ram_rd_data;
   logic [TICK_WIDTH-1:0] dec_cnt;

   logic                  accept;
   logic                  out_free;
   logic [PRIO_W-1:0]     pick;
   logic                  do_switch;
   logic [PRIO_W-1:0]     create_idx;

   function automatic logic [PRIO_W-1:0] first_set(input logic [PRIO_COUNT-1:0] r);
      logic [PRIO_COUNT-1:0] iso;
      logic [PRIO_W-1:0]     idx;
      iso = r & (~r + PRIO_COUNT'(1));
      idx = '0;
      for (int k = 0; k < PRIO_COUNT; k++) begin
         if (iso[k]) begin
            idx = idx | PRIO_W'(k);
         end
      end
      return idx;
   endfunction

   pbts_ram #(
      .WIDTH (TICK_WIDTH),
      .DEPTH (PRIO_COUNT)
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign create_idx    = PRIO_W'(req_bus.prio);
   assign ram_rd_addr   = cnt_ff[PRIO_W-1:0];
   assign dec_cnt       = ram_rd_data - TICK_WIDTH'(1);
   assign pick          = first_set(ready_ff);
   assign do_switch     = sched_ff && (lock_ff == '0) && (ready_ff != '0)
                          && (pick != running_ff);

   always_comb begin
      state_in      = state_ff;
      ready_in      = ready_ff;
      delayed_in    = delayed_ff;
      lock_in       = lock_ff;
      running_in    = running_ff;
      sched_in      = sched_ff;
      cnt_in        = cnt_ff;
      wb_vld_in     = 1'b0;
      wb_idx_in     = ram_rd_addr;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_prio_in   = rsp_prio_ff;
      rsp_switch_in = rsp_switch_ff;
      rsp_none_in   = rsp_none_ff;
      rsp_lock_in   = rsp_lock_ff;
      rsp_mask_in   = rsp_mask_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = wb_idx_ff;
      ram_wr_data   = dec_cnt;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_SCHED;
               sched_in = 1'b0;
               unique case (req_bus.func)
                  FUNC_CREATE: begin
                     if (int'(req_bus.prio) < PRIO_COUNT) begin
                        ready_in[create_idx]   = 1'b1;
                        delayed_in[create_idx] = 1'b0;
                     end
                  end
                  FUNC_DELAY: begin
                     ram_wr_en              = 1'b1;
                     ram_wr_addr            = running_ff;
                     ram_wr_data            = req_bus.ticks[TICK_WIDTH-1:0];
                     delayed_in[running_ff] = 1'b1;
                     ready_in[running_ff]   = 1'b0;
                     sched_in               = 1'b1;
                  end
                  FUNC_TICK: begin
                     state_in = S_WALK;
                     cnt_in   = '0;
                     sched_in = 1'b1;
                  end
                  FUNC_LOCK: begin
                     if (lock_ff != LOCK_MAX) begin
                        lock_in = lock_ff + LOCK_W'(1);
                     end
                  end
                  FUNC_UNLOCK: begin
                     if (lock_ff != '0) begin
                        lock_in  = lock_ff - LOCK_W'(1);
                        sched_in = (lock_ff == LOCK_W'(1));
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_WALK: begin
            if (int'(cnt_ff) < PRIO_COUNT) begin
               cnt_in    = cnt_ff + CNT_W'(1);
               wb_vld_in = 1'b1;
            end else begin
               state_in = S_SCHED;
            end
            if (wb_vld_ff && delayed_ff[wb_idx_ff]) begin
               ram_wr_en = 1'b1;
               if (dec_cnt == '0) begin
                  delayed_in[wb_idx_ff] = 1'b0;
                  ready_in[wb_idx_ff]   = 1'b1;
               end
            end
         end
         S_SCHED: begin
            if (out_free) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_switch_in = do_switch;
               rsp_prio_in   = PRIO_FLD_W'(do_switch ? pick : running_ff);
               rsp_none_in   = (ready_ff == '0);
               rsp_lock_in   = lock_ff;
               rsp_mask_in   = MASK_W'(ready_ff);
               if (do_switch) begin
                  running_in = pick;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ready_ff     <= '0;
         delayed_ff   <= '0;
         lock_ff      <= '0;
         running_ff   <= '0;
         sched_ff     <= 1'b0;
         cnt_ff       <= '0;
         wb_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ready_ff     <= ready_in;
         delayed_ff   <= delayed_in;
         lock_ff      <= lock_in;
         running_ff   <= running_in;
         sched_ff     <= sched_in;
         cnt_ff       <= cnt_in;
         wb_vld_ff    <= wb_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wb_idx_ff     <= wb_idx_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_switch_ff <= rsp_switch_in;
      rsp_none_ff   <= rsp_none_in;
      rsp_lock_ff   <= rsp_lock_in;
      rsp_mask_ff   <= rsp_mask_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.next_prio  = rsp_prio_ff;
   assign rsp_bus.switch_now = rsp_switch_ff;
   assign rsp_bus.none_ready = rsp_none_ff;
   assign rsp_bus.lock_depth = rsp_lock_ff;
   assign rsp_bus.ready_mask = rsp_mask_ff;

`ifndef SYNTHESIS
   a_ready_delayed_disjoint: assert property (@(posedge clock) disable iff (reset)
      (ready_ff & delayed_ff) == '0)
      else $error("task both ready and delayed");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_bus.ready)
      else $error("request accepted while another is in flight");

   a_result_from_sched: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_SCHED)
      else $error("result raised outside the schedule step");

   // checked on the cycle a fresh result is loaded
   a_switch_to_ready: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_switch_ff && state_ff == S_IDLE && $past(state_ff) == S_SCHED)
      |-> ready_ff[running_ff])
      else $error("switch to a task that is not ready");
`endif

endmodule

`default_nettype wire

>>> tb/pbts_checker.sv
// ----------------------------------------------------------------------------
// pbts_checker
// Scoreboard for the priority bitmap scheduler. Every accepted request is
// run through a local model of the ready and delay bitmaps, the per-task
// tick counters, the lock nesting and the running task. The status the
// model expects is queued and compared field by field with each accepted
// response. Failures and the number of outstanding responses go to the
// testbench top.
// ----------------------------------------------------------------------------
`default_nettype none

module pbts_checker import pbts_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   pbts_req_if         req_bus,
   pbts_rsp_if         rsp_bus,
   output int unsigned fail_count,
   output int unsigned pending
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [PRIO_FLD_W-1:0] next_prio;
      logic                  switch_now;
      logic                  none_ready;
      logic [LOCK_W-1:0]     lock_depth;
      logic [MASK_W-1:0]     ready_mask;
   } sched_status_type;

   logic [MASK_W-1:0]      ready_set;
   logic [MASK_W-1:0]      delayed_set;
   logic [TICKS_FLD_W-1:0] ticks_left [MASK_W];
   logic [LOCK_W-1:0]      lock_level;
   logic [PRIO_FLD_W-1:0]  running_task;

   sched_status_type expected_status [$];
   int unsigned      failures = 0;

   // lowest ready priority wins; nothing happens while locked or idle
   function automatic logic reschedule();
      logic [PRIO_FLD_W-1:0] pick;
      pick = '0;
      if (lock_level != '0 || ready_set == '0) return 1'b0;
      for (int i = MASK_W - 1; i >= 0; i--) begin
         if (ready_set[i]) pick = PRIO_FLD_W'(i);
      end
      if (pick == running_task) return 1'b0;
      running_task = pick;
      return 1'b1;
   endfunction

   function automatic sched_status_type schedule_call(
      input logic [FUNC_W-1:0]      func,
      input logic [PRIO_FLD_W-1:0]  prio,
      input logic [TICKS_FLD_W-1:0] ticks
   );
      logic             switched;
      sched_status_type status;
      switched = 1'b0;
      case (func)
         FUNC_CREATE: begin
            ready_set[prio]   = 1'b1;
            delayed_set[prio] = 1'b0;
            ticks_left[prio]  = '0;
         end
         FUNC_DELAY: begin
            ticks_left[running_task]  = ticks;
            delayed_set[running_task] = 1'b1;
            ready_set[running_task]   = 1'b0;
            switched = reschedule();
         end
         FUNC_TICK: begin
            for (int i = 0; i < MASK_W; i++) begin
               if (delayed_set[i]) begin
                  ticks_left[i] = ticks_left[i] - TICKS_FLD_W'(1);
                  if (ticks_left[i] == '0) begin
                     delayed_set[i] = 1'b0;
                     ready_set[i]   = 1'b1;
                  end
               end
            end
            switched = reschedule();
         end
         FUNC_LOCK: begin
            if (lock_level != LOCK_MAX) lock_level = lock_level + LOCK_W'(1);
         end
         FUNC_UNLOCK: begin
            if (lock_level != '0) begin
               lock_level = lock_level - LOCK_W'(1);
               if (lock_level == '0) switched = reschedule();
            end
         end
         default: ;
      endcase
      status.next_prio  = running_task;
      status.switch_now = switched;
      status.none_ready = (ready_set == '0);
      status.lock_depth = lock_level;
      status.ready_mask = ready_set;
      return status;
   endfunction

   always @(posedge clock) begin : watch
      sched_status_type want;
      sched_status_type got;
      if (reset) begin
         ready_set    = '0;
         delayed_set  = '0;
         lock_level   = '0;
         running_task = '0;
         for (int i = 0; i < MASK_W; i++) ticks_left[i] = '0;
         expected_status.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{next_prio:  rsp_bus.next_prio,
                    switch_now: rsp_bus.switch_now,
                    none_ready: rsp_bus.none_ready,
                    lock_depth: rsp_bus.lock_depth,
                    ready_mask: rsp_bus.ready_mask};
            if (expected_status.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("%0t: response with no request outstanding: prio=%0d sw=%0b",
                           $realtime, got.next_prio, got.switch_now);
            end else begin
               want = expected_status.pop_front();
               if (got !== want) begin
                  failures++;
                  if (failures <= 10) begin
                     $display("%0t: mismatch: expected prio=%0d sw=%0b none=%0b lock=%0d mask=%h",
                              $realtime, want.next_prio, want.switch_now, want.none_ready,
                              want.lock_depth, want.ready_mask);
                     $display("%0t: mismatch: got      prio=%0d sw=%0b none=%0b lock=%0d mask=%h",
                              $realtime, got.next_prio, got.switch_now, got.none_ready,
                              got.lock_depth, got.ready_mask);
                  end
               end
            end
         end
         if (req_bus.valid && req_bus.ready)
            expected_status.push_back(schedule_call(req_bus.func, req_bus.prio,
                                                    req_bus.ticks));
      end
      fail_count <= failures;
      pending    <= expected_status.size();
   end

endmodule

`default_nettype wire

>>> tb/priority_bitmap_task_scheduler_top_tb.sv
// ----------------------------------------------------------------------------
// priority_bitmap_task_scheduler_top_tb
// Drives scheduler calls into the block: a directed pass over the corner
// cases (wrapping delay, locked scheduling, redelay, restart of a delayed
// task, unused codes), then random call mixes with small tick counts so
// tasks cycle through ready and delayed, plus a lock storm past the
// saturation point. Both channels idle at random and the response side
// holds off once for a long stretch. The checker predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_bitmap_task_scheduler_top_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import pbts_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED_FIRST = FUNC_UNLOCK + FUNC_W'(1);
   localparam logic [FUNC_W-1:0] FUNC_UNUSED_LAST  = '1;
   localparam int RANDOM_CALLS = 605;
   localparam int STORM_DEPTH  = 260;

   logic        clock;
   logic        reset;
   int unsigned fail_count;
   int unsigned pending;
   int unsigned burst_left = 0;

   pbts_req_if req_bus ();
   pbts_rsp_if rsp_bus ();

   priority_bitmap_task_scheduler_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   pbts_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("priority_bitmap_task_scheduler_top_tb failed");
      $finish;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // returns at the accepting edge; valid stays high if no gap follows
   task automatic issue_call(
      input logic [FUNC_W-1:0]      func,
      input logic [PRIO_FLD_W-1:0]  prio,
      input logic [TICKS_FLD_W-1:0] ticks
   );
      int unsigned gap;
      req_bus.valid <= 1'b1;
      req_bus.func  <= func;
      req_bus.prio  <= prio;
      req_bus.ticks <= ticks;
      do @(posedge clock); while (!req_bus.ready);
      if (burst_left == 0 && $urandom_range(0, 49) == 0) burst_left = $urandom_range(10, 30);
      if (burst_left != 0) begin
         burst_left--;
         gap = 0;
      end else begin
         gap = pick_gap();
      end
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // response side: random stalls, ready stretches and one long hold-off
   initial begin : rsp_drain
      int unsigned low_left;
      int unsigned high_left;
      int unsigned taken;
      bit          hold_done;
      low_left  = 0;
      high_left = 0;
      taken     = 0;
      hold_done = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) taken++;
         if (!hold_done && taken == 150) begin
            hold_done = 1'b1;
            low_left  = 600;
            high_left = 0;
         end
         if (low_left != 0) begin
            low_left--;
            rsp_bus.ready <= 1'b0;
         end else if (high_left != 0) begin
            high_left--;
            rsp_bus.ready <= 1'b1;
         end else begin
            high_left = ($urandom_range(0, 99) < 15) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 2);
            low_left  = pick_gap();
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int unsigned            r;
      logic [FUNC_W-1:0]      func;
      logic [TICKS_FLD_W-1:0] ticks;

      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.func  <= FUNC_CREATE;
      req_bus.prio  <= '0;
      req_bus.ticks <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      issue_call(FUNC_UNLOCK, '0, '0);
      issue_call(FUNC_TICK, '1, '1);
      // zero delay wraps, task 0 stays parked until created again
      issue_call(FUNC_DELAY, '0, '0);
      issue_call(FUNC_CREATE, 5'd31, 32'($urandom));
      issue_call(FUNC_TICK, 5'($urandom), 32'($urandom));
      // restart of a delayed task
      issue_call(FUNC_CREATE, 5'd0, 32'($urandom));
      issue_call(FUNC_CREATE, 5'd21, 32'($urandom));
      issue_call(FUNC_CREATE, 5'd10, 32'($urandom));
      issue_call(FUNC_DELAY, 5'($urandom), 32'd2);
      issue_call(FUNC_LOCK, 5'($urandom), 32'($urandom));
      issue_call(FUNC_CREATE, 5'd0, 32'($urandom));
      // locked: delay and tick must not switch
      issue_call(FUNC_DELAY, 5'($urandom), 32'd1);
      issue_call(FUNC_TICK, 5'($urandom), 32'($urandom));
      issue_call(FUNC_LOCK, 5'($urandom), 32'($urandom));
      issue_call(FUNC_UNLOCK, 5'($urandom), 32'($urandom));
      issue_call(FUNC_UNLOCK, 5'($urandom), 32'($urandom));
      issue_call(FUNC_TICK, 5'($urandom), 32'($urandom));
      issue_call(FUNC_DELAY, 5'($urandom), 32'hFFFF_FFFF);
      issue_call(FUNC_DELAY, 5'($urandom), 32'hAAAA_AAAA);
      issue_call(FUNC_DELAY, 5'($urandom), 32'h5555_5555);
      // nothing ready, then redelay overwrites the count
      issue_call(FUNC_DELAY, 5'($urandom), 32'd3);
      issue_call(FUNC_DELAY, 5'($urandom), 32'd1);
      issue_call(FUNC_TICK, 5'($urandom), 32'($urandom));
      for (int c = FUNC_UNUSED_FIRST; c <= FUNC_UNUSED_LAST; c++)
         issue_call(FUNC_W'(c), 5'($urandom), 32'($urandom));
      drain_results();

      for (int n = 0; n < RANDOM_CALLS; n++) begin
         if (n == 250) drain_results();
         if (n == 300) begin
            // lock nesting past saturation and back down to zero
            for (int k = 0; k < STORM_DEPTH; k++)
               issue_call(FUNC_LOCK, 5'($urandom), 32'($urandom));
            for (int k = 0; k < STORM_DEPTH; k++)
               issue_call(FUNC_UNLOCK, 5'($urandom), 32'($urandom));
         end
         r = $urandom_range(0, 99);
         if (r < 20)      func = FUNC_CREATE;
         else if (r < 40) func = FUNC_DELAY;
         else if (r < 73) func = FUNC_TICK;
         else if (r < 85) func = FUNC_LOCK;
         else if (r < 97) func = FUNC_UNLOCK;
         else             func = FUNC_UNUSED_FIRST + FUNC_W'($urandom_range(0, 2));
         r = $urandom_range(0, 99);
         if (r < 75)      ticks = $urandom_range(1, 6);
         else if (r < 80) ticks = '0;
         else if (r < 90) ticks = $urandom_range(7, 40);
         else             ticks = $urandom;
         issue_call(func, 5'($urandom), ticks);
      end

      drain_results();
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("priority_bitmap_task_scheduler_top_tb passed");
      end else begin
         $display("priority_bitmap_task_scheduler_top_tb failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
